FILE: design/pim_pkg.sv
package pim_pkg;

    localparam int MAX_SIZE  = 8;
    localparam int IDX_W     = 16;
    localparam int SIZE_W    = 4;
    localparam int VAL_W     = 3;
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW   = 5;

    typedef logic [VAL_W-1:0] val_t;
    typedef val_t [MAX_SIZE-1:0] perm_t;

    // classified request passed from front to back
    typedef struct packed {
        logic             err;
        logic [SIZE_W-1:0] n;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             err;
    } res_t;

    function automatic logic [IDX_W-1:0] fact(input logic [SIZE_W-1:0] k);
        logic [IDX_W-1:0] f;
        case (k)
            4'd0, 4'd1: f = 16'd1;
            4'd2: f = 16'd2;
            4'd3: f = 16'd6;
            4'd4: f = 16'd24;
            4'd5: f = 16'd120;
            4'd6: f = 16'd720;
            4'd7: f = 16'd5040;
            default: f = 16'd40320;
        endcase
        return f;
    endfunction

    function automatic logic [16:0] fact_full(input logic [SIZE_W-1:0] k);
        return (k >= 4'd8) ? 17'd40320 : {1'b0, fact(k)};
    endfunction

endpackage

FILE: design/permutation_index_multiply.sv
// Permutation index multiplier.
// Input channel: drive first_index/second_index and raise push while full is
// low; each accepted request yields one result. Output channel: while empty is
// low, product_index/index_error show the oldest result; pop takes it.
// The front clamps the size and range-checks each request; the back unranks
// it over eight stages (one factorial digit per stage), composes, then ranks
// over eight more stages (one weighted inversion count per stage) and writes
// a 32-entry output queue.
// Throughput is one request per cycle while full is low. full rises once 21
// requests are accepted and not yet popped, so the queue always has room for
// every result still in the pipeline; with pop held high at most 19 are
// outstanding and full stays low. When the consumer stalls, results collect
// in the queue and full holds the input after 21 outstanding requests.
// perm_size (APB address 0) is read and written through the APB port and
// resets to 8; write it only while idle. Reset empties pipeline and queue.
// Index error: either index at or above n! gives index_error=1, index 0.
module permutation_index_multiply (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] first_index,
    input  logic [15:0] second_index,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] product_index,
    output logic        index_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int PIPE = pim_pkg::MAX_SIZE * 2 + 1;
    localparam int QD   = PIPE + 4;

    logic [pim_pkg::SIZE_W-1:0] size_reg;
    logic          acc, rvalid, pop_acc, req_valid;
    pim_pkg::req_t req;
    pim_pkg::res_t res, head;
    logic [5:0]    fly_reg;
    logic [pim_pkg::FIFO_AW:0] q_count;

    assign pready = 1'b1;
    assign prdata = {28'd0, size_reg};
    assign acc = push && !full;
    assign pop_acc = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) size_reg <= 4'd8;
        else if (psel && penable && pwrite && !paddr) size_reg <= pwdata[3:0];
    end

    pim_front u_front (.clk(clk), .rst_n(rst_n), .in_valid(acc), .a(first_index),
                       .b(second_index), .size_cfg(size_reg), .req_valid(req_valid),
                       .req(req));
    pim_back u_back (.clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req(req),
                     .res_valid(rvalid), .res(res));
    pim_fifo u_queue (.clk(clk), .rst_n(rst_n), .wr(rvalid), .wdata(res), .rd(pop_acc),
                      .rdata(head), .empty(empty), .count(q_count));

    // fly_reg counts accepted requests not yet popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fly_reg <= '0;
        else
            fly_reg <= fly_reg + 6'(acc) - 6'(pop_acc);
    end

    assign full = (fly_reg >= 6'(QD));
    assign product_index = head.index;
    assign index_error = head.err;

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= fly_reg) else $error("queue exceeds outstanding");
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fly_reg <= 6'(QD)) else $error("outstanding overflow");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && index_error) |-> product_index == '0) else $error("error index");
endmodule

FILE: design/pim_front.sv
module pim_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [pim_pkg::IDX_W-1:0] a,
    input  logic [pim_pkg::IDX_W-1:0] b,
    input  logic [pim_pkg::SIZE_W-1:0] size_cfg,
    output logic                      req_valid,
    output pim_pkg::req_t             req
);
    logic [pim_pkg::SIZE_W-1:0] n;
    logic [16:0]                lim;
    logic                       req_valid_reg;
    pim_pkg::req_t              req_reg;

    always_comb
    begin
        n = size_cfg;
        if (n < 4'd1) n = 4'd1;
        if (n > 4'(pim_pkg::MAX_SIZE)) n = 4'(pim_pkg::MAX_SIZE);
        lim = pim_pkg::fact_full(n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else
            req_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            req_reg.n   <= n;
            req_reg.a   <= a;
            req_reg.b   <= b;
            req_reg.err <= ({1'b0, a} >= lim) || ({1'b0, b} >= lim);
        end
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;
endmodule

FILE: design/pim_back.sv
module pim_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  pim_pkg::req_t req,
    output logic          res_valid,
    output pim_pkg::res_t res
);
    localparam int M = pim_pkg::MAX_SIZE;
    // stage regs: unrank digit per stage
    logic                              v_reg   [M];
    pim_pkg::req_t                     q_reg   [M];
    logic [pim_pkg::IDX_W-1:0]         ra_reg  [M];
    logic [pim_pkg::IDX_W-1:0]         rb_reg  [M];
    pim_pkg::perm_t                    avx_reg [M];
    pim_pkg::perm_t                    avy_reg [M];
    pim_pkg::perm_t                    px_reg  [M];
    pim_pkg::perm_t                    py_reg  [M];
    // rank stages
    logic                              rv_reg  [M];
    pim_pkg::perm_t                    pp_reg  [M];
    logic [pim_pkg::IDX_W-1:0]         sum_reg [M];
    logic                              re_reg  [M];
    logic [pim_pkg::SIZE_W-1:0]        rn_reg  [M];
    pim_pkg::perm_t                    id_perm;
    pim_pkg::perm_t                    pp_first;

    function automatic void digit(input logic [pim_pkg::SIZE_W-1:0] n, input int i,
                                  input logic [pim_pkg::IDX_W-1:0] r,
                                  input pim_pkg::perm_t av,
                                  output logic [pim_pkg::IDX_W-1:0] r_o,
                                  output pim_pkg::perm_t av_o, output pim_pkg::val_t v);
        logic [pim_pkg::IDX_W-1:0] w;
        logic [pim_pkg::IDX_W+2:0] m;
        logic [pim_pkg::IDX_W+2:0] sel;
        logic [3:0] d;
        logic [3:0] left;
        w = pim_pkg::fact(4'(n - 4'd1 - 4'(i)));
        // quotient of an in-range index is at most 7: compare against all seven multiples at once
        d = 4'd0;
        sel = '0;
        for (int k = 1; k < 8; k++)
        begin
            m = (pim_pkg::IDX_W+3)'(w) * (pim_pkg::IDX_W+3)'(k);
            if ({3'b000, r} >= m)
            begin
                d = 4'(k);
                sel = m;
            end
        end
        r_o = r - sel[pim_pkg::IDX_W-1:0];
        left = 4'(n - 4'(i));
        if (d >= left) d = left - 4'd1;
        v = av[d[2:0]];
        av_o = av;
        for (int k = 0; k < M - 1; k++)
            if (4'(k) >= d) av_o[k] = av[k+1];
    endfunction

    always_comb
    begin
        for (int k = 0; k < M; k++) id_perm[k] = pim_pkg::val_t'(k);
    end

    for (genvar s = 0; s < M; s++)
    begin : g_un
        logic                      v_i;
        pim_pkg::req_t             q_i;
        logic [pim_pkg::IDX_W-1:0] ra_i, rb_i, ra_n, rb_n;
        pim_pkg::perm_t            ax_i, ay_i, px_i, py_i;
        pim_pkg::perm_t            ax_n, ay_n, px_n, py_n;
        pim_pkg::val_t             vx, vy;
        if (s == 0)
        begin : g_src
            always_comb
            begin
                v_i  = req_valid;
                q_i  = req;
                ra_i = req.a;
                rb_i = req.b;
                ax_i = id_perm;
                ay_i = id_perm;
                px_i = '0;
                py_i = '0;
            end
        end
        else
        begin : g_src
            always_comb
            begin
                v_i  = v_reg[s-1];
                q_i  = q_reg[s-1];
                ra_i = ra_reg[s-1];
                rb_i = rb_reg[s-1];
                ax_i = avx_reg[s-1];
                ay_i = avy_reg[s-1];
                px_i = px_reg[s-1];
                py_i = py_reg[s-1];
            end
        end
        always_comb
        begin
            digit(q_i.n, s, ra_i, ax_i, ra_n, ax_n, vx);
            digit(q_i.n, s, rb_i, ay_i, rb_n, ay_n, vy);
            px_n = px_i;
            py_n = py_i;
            if (4'(s) < q_i.n)
            begin
                px_n[s] = vx;
                py_n[s] = vy;
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) v_reg[s] <= 1'b0;
            else        v_reg[s] <= v_i;
        end
        always_ff @(posedge clk)
        begin
            q_reg[s]   <= q_i;
            ra_reg[s]  <= ra_n;
            rb_reg[s]  <= rb_n;
            avx_reg[s] <= ax_n;
            avy_reg[s] <= ay_n;
            px_reg[s]  <= px_n;
            py_reg[s]  <= py_n;
        end
    end

    // compose into rank pipeline entry
    always_comb
    begin
        logic [3:0] sv;
        for (int i = 0; i < M; i++)
        begin
            sv = {1'b0, px_reg[M-1][i]};
            if (sv >= q_reg[M-1].n) sv = q_reg[M-1].n - 4'd1;
            pp_first[i] = py_reg[M-1][sv[2:0]];
        end
    end

    for (genvar s = 0; s < M; s++)
    begin : g_rk
        logic                       rv_i;
        pim_pkg::perm_t             pp_i;
        logic [pim_pkg::IDX_W-1:0]  sum_i;
        logic                       re_i;
        logic [pim_pkg::SIZE_W-1:0] n_i;
        logic [pim_pkg::IDX_W-1:0]  sum_n;
        logic [3:0]                 cnt;
        if (s == 0)
        begin : g_src
            always_comb
            begin
                rv_i  = v_reg[M-1];
                pp_i  = pp_first;
                sum_i = '0;
                re_i  = q_reg[M-1].err;
                n_i   = q_reg[M-1].n;
            end
        end
        else
        begin : g_src
            always_comb
            begin
                rv_i  = rv_reg[s-1];
                pp_i  = pp_reg[s-1];
                sum_i = sum_reg[s-1];
                re_i  = re_reg[s-1];
                n_i   = rn_reg[s-1];
            end
        end
        always_comb
        begin
            cnt = '0;
            for (int j = s + 1; j < M; j++)
                if (4'(j) < n_i && pp_i[j] < pp_i[s]) cnt = cnt + 4'd1;
            sum_n = sum_i;
            if (4'(s) < n_i)
                sum_n = sum_i + 16'(cnt * pim_pkg::fact(4'(n_i - 4'd1 - 4'(s))));
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) rv_reg[s] <= 1'b0;
            else        rv_reg[s] <= rv_i;
        end
        always_ff @(posedge clk)
        begin
            pp_reg[s]  <= pp_i;
            sum_reg[s] <= sum_n;
            re_reg[s]  <= re_i;
            rn_reg[s]  <= n_i;
        end
    end

    assign res_valid = rv_reg[M-1];
    assign res.err   = re_reg[M-1];
    assign res.index = re_reg[M-1] ? '0 : sum_reg[M-1];
endmodule

FILE: design/pim_fifo.sv
module pim_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  pim_pkg::res_t wdata,
    input  logic          rd,
    output pim_pkg::res_t rdata,
    output logic          empty,
    output logic [pim_pkg::FIFO_AW:0] count
);
    localparam int AW = pim_pkg::FIFO_AW;
    pim_pkg::res_t mem [pim_pkg::FIFO_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          hv_reg;
    pim_pkg::res_t head_reg;
    logic          load;

    // refill the head register from memory when it is free or being popped
    assign load = (cnt_reg != '0) && (!hv_reg || rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0; hv_reg <= 1'b0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (load) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(load);
            if (load) hv_reg <= 1'b1;
            else if (rd) hv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem[wp_reg] <= wdata;
        if (load) head_reg <= mem[rp_reg];
    end

    assign rdata = head_reg;
    assign empty = !hv_reg;
    assign count = cnt_reg + (AW+1)'(hv_reg);
endmodule

FILE: tb/sv/tb_permutation_index_multiply.sv
`timescale 1ns / 100ps

module tb_permutation_index_multiply;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 20000;

    typedef struct {
        logic [15:0] index;
        logic        err;
    } product_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [15:0] first_index;
    logic [15:0] second_index;
    logic        empty;
    logic        pop;
    logic [15:0] product_index;
    logic        index_error;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    product_t    pending_products[$];
    logic [3:0]  size_reg;
    int          mismatch_count;
    int          idle_count;
    bit          calm_mode;
    bit          hold_off;
    bit          timed_out;

    permutation_index_multiply dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .first_index  (first_index),
        .second_index (second_index),
        .empty        (empty),
        .pop          (pop),
        .product_index(product_index),
        .index_error  (index_error),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int unsigned size_of(input logic [3:0] raw);
        if (raw == 4'd0)
            return 1;
        if (raw > 4'd8)
            return 8;
        return {28'd0, raw};
    endfunction

    function automatic int unsigned factorial_of(input int unsigned k);
        int unsigned f;
        f = 1;
        for (int unsigned i = 2; i <= k; i++)
            f = f * i;
        return f;
    endfunction

    function automatic void unrank_perm(input int unsigned n, input int unsigned rank,
                                        output logic [2:0] perm[8]);
        logic [2:0]  avail[8];
        int unsigned r;
        int unsigned w;
        int unsigned d;
        r = rank;
        for (int unsigned i = 0; i < 8; i++)
            avail[i] = i[2:0];
        for (int unsigned i = 0; i < n; i++)
        begin
            w = factorial_of(n - 1 - i);
            d = r / w;
            r = r % w;
            if (d >= n - i)
                d = n - i - 1;
            perm[i] = avail[d];
            for (int unsigned k = d; k + 1 < n - i; k++)
                avail[k] = avail[k + 1];
        end
    endfunction

    function automatic product_t compose_ranks(input logic [3:0] raw, input logic [15:0] a,
                                               input logic [15:0] b);
        product_t    res;
        int unsigned n;
        int unsigned sum;
        int unsigned cnt;
        logic [2:0]  px[8];
        logic [2:0]  py[8];
        logic [2:0]  pp[8];
        n = size_of(raw);
        res.index = '0;
        res.err = 1'b0;
        if (a >= factorial_of(n) || b >= factorial_of(n))
        begin
            res.err = 1'b1;
            return res;
        end
        unrank_perm(n, a, px);
        unrank_perm(n, b, py);
        for (int unsigned i = 0; i < n; i++)
            pp[i] = py[(px[i] >= n) ? n - 1 : px[i]];
        sum = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            cnt = 0;
            for (int unsigned j = i + 1; j < n; j++)
                if (pp[j] < pp[i])
                    cnt++;
            sum += cnt * factorial_of(n - 1 - i);
        end
        res.index = sum[15:0];
        return res;
    endfunction

    task automatic send_request(input logic [15:0] a, input logic [15:0] b);
        while (!calm_mode && $urandom_range(99) < 23)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        first_index = a;
        second_index = b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_products.push_back(compose_ranks(size_reg, a, b));
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_products.size() != 0 && !timed_out)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(input logic [3:0] value);
        wait_idle();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = 1'b0;
        pwdata = {28'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        size_reg = value;
    endtask

    task automatic random_request(input int unsigned n);
        int unsigned lim;
        lim = factorial_of(n);
        if ($urandom_range(99) < 8)
            send_request(16'($urandom), 16'($urandom));
        else
            send_request(16'($urandom_range(lim - 1)), 16'($urandom_range(lim - 1)));
    endtask

    task automatic test_directed_extremes();
        send_request(16'd0, 16'd0);
        send_request(16'd40319, 16'd40319);
        send_request(16'd40319, 16'd0);
        send_request(16'd1, 16'd40318);
        send_request(16'd40320, 16'd5);
        send_request(16'd5, 16'd40320);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'h5555, 16'h2AAA);
        send_request(16'h2AAA, 16'h5555);
        write_size(4'd0);
        send_request(16'd0, 16'd0);
        send_request(16'd1, 16'd0);
        write_size(4'd15);
        send_request(16'd40319, 16'd12345);
        send_request(16'd12345, 16'd40320);
        write_size(4'd3);
        send_request(16'd5, 16'd3);
        send_request(16'd6, 16'd0);
        write_size(4'd2);
        send_request(16'd1, 16'd1);
        send_request(16'd2, 16'd1);
    endtask

    task automatic test_random_sizes();
        logic [3:0] value;
        for (int s = 0; s < 8; s++)
        begin
            value = (s == 0) ? 4'd8 : 4'($urandom_range(15));
            write_size(value);
            for (int i = 0; i < 120; i++)
                random_request(size_of(value));
        end
    endtask

    task automatic test_back_pressure();
        write_size(4'd8);
        hold_off = 1'b1;
        calm_mode = 1'b1;
        fork
            repeat (60) random_request(8);
            begin
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
        join
        for (int i = 0; i < 250; i++)
            random_request(8);
        calm_mode = 1'b0;
    endtask

    task automatic test_full_size_stream();
        write_size(4'd8);
        for (int i = 0; i < 160; i++)
            random_request(8);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            pop <= 1'b0;
        else
            pop <= calm_mode || ($urandom_range(99) >= 23);
    end

    always @(posedge clk)
    begin
        product_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_products.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result index=%0d err=%0b",
                             product_index, index_error);
            end
            else
            begin
                want = pending_products.pop_front();
                if (product_index !== want.index || index_error !== want.err)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected index=%0d err=%0b, got index=%0d err=%0b",
                                 want.index, want.err, product_index, index_error);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            timed_out = 1'b1;
            $display("tb_permutation_index_multiply: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        first_index = '0;
        second_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 1'b0;
        pwdata = '0;
        size_reg = 4'd8;
        calm_mode = 1'b0;
        hold_off = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_extremes();
        test_random_sizes();
        test_back_pressure();
        test_full_size_stream();
        wait_idle();
        if (mismatch_count == 0 && pending_products.size() == 0)
            $display("tb_permutation_index_multiply: PASS");
        else
            $display("tb_permutation_index_multiply: FAIL");
        $finish;
    end

endmodule
